// ----- rtl/core/tdpu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdpu_pkg
// Shared types and constants for the Thumb data-processing unit.
// ----------------------------------------------------------------------------
package tdpu_pkg;

  localparam int unsigned RegAw = 3;
  localparam int unsigned RegDepth = 8;
  localparam int unsigned DataW = 32;

  localparam logic [3:0] AluAnd = 4'h0;
  localparam logic [3:0] AluEor = 4'h1;
  localparam logic [3:0] AluLsl = 4'h2;
  localparam logic [3:0] AluLsr = 4'h3;
  localparam logic [3:0] AluAsr = 4'h4;
  localparam logic [3:0] AluAdc = 4'h5;
  localparam logic [3:0] AluSbc = 4'h6;
  localparam logic [3:0] AluRor = 4'h7;
  localparam logic [3:0] AluTst = 4'h8;
  localparam logic [3:0] AluNeg = 4'h9;
  localparam logic [3:0] AluCmp = 4'hA;
  localparam logic [3:0] AluCmn = 4'hB;
  localparam logic [3:0] AluOrr = 4'hC;
  localparam logic [3:0] AluMul = 4'hD;
  localparam logic [3:0] AluBic = 4'hE;
  localparam logic [3:0] AluMvn = 4'hF;

  typedef struct packed {
    logic        handled;
    logic        wr;
    logic [2:0]  rd;
    logic [31:0] res;
    logic [3:0]  nzcv;
  } exec_res_t;

endpackage
`default_nettype wire

// ----- rtl/core/tdpu_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdpu_ram
// Generic synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tdpu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- rtl/core/tdpu_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdpu_alu
// Decode and execute one Thumb data-processing word on forwarded operands.
// ----------------------------------------------------------------------------
module tdpu_alu (
  input  wire logic [15:0]        instr,
  input  wire logic [31:0]        reg_a,
  input  wire logic [31:0]        reg_b,
  input  wire logic [3:0]         nzcv,
  output tdpu_pkg::exec_res_t     res
);

  logic [31:0] x, s, a, b, r;
  logic [32:0] sum;
  logic        n, z, c, v, hd, wr, setnz, do_add;
  logic [2:0]  rd;
  logic [4:0]  sh;
  logic [7:0]  amt;
  logic [3:0]  op4;
  logic        cin;

  always_comb begin
    x = reg_b;
    s = reg_b;
    n = nzcv[3]; z = nzcv[2]; c = nzcv[1]; v = nzcv[0];
    hd = 1'b0; wr = 1'b0; setnz = 1'b0; rd = 3'd0; r = '0;
    a = '0; b = '0; cin = 1'b0; do_add = 1'b0;
    sh = instr[10:6];
    amt = reg_b[7:0];
    op4 = instr[9:6];
    if (instr[15:13] == 3'b000 && instr[12:11] != 2'b11) begin
      hd = 1'b1; wr = 1'b1; setnz = 1'b1; rd = instr[2:0];
      case (instr[12:11])
        2'd0: begin
          r = x << sh;
          if (sh != 5'd0) c = x[5'(6'd32 - {1'b0, sh})];
        end
        2'd1: begin
          if (sh == 5'd0) begin
            c = x[31]; r = '0;
          end else begin
            c = x[sh - 5'd1]; r = x >> sh;
          end
        end
        default: begin
          if (sh == 5'd0) begin
            c = x[31]; r = {32{x[31]}};
          end else begin
            c = x[sh - 5'd1]; r = $signed(x) >>> sh;
          end
        end
      endcase
    end else if (instr[15:11] == 5'b00011) begin
      hd = 1'b1; wr = 1'b1; setnz = 1'b1; rd = instr[2:0]; do_add = 1'b1;
      a = reg_a;
      b = instr[10] ? {29'd0, instr[8:6]} : reg_b;
      if (instr[9]) begin
        b = ~b; cin = 1'b1;
      end
    end else if (instr[15:13] == 3'b001) begin
      hd = 1'b1; setnz = 1'b1; rd = instr[10:8];
      a = reg_a; b = {24'd0, instr[7:0]};
      case (instr[12:11])
        2'd0: begin
          r = b; wr = 1'b1;
        end
        2'd1: begin
          do_add = 1'b1; b = ~b; cin = 1'b1;
        end
        2'd2: begin
          do_add = 1'b1; wr = 1'b1;
        end
        default: begin
          do_add = 1'b1; b = ~b; cin = 1'b1; wr = 1'b1;
        end
      endcase
    end else if (instr[15:10] == 6'b010000) begin
      hd = 1'b1; setnz = 1'b1; wr = 1'b1; rd = instr[2:0];
      a = reg_a;
      unique case (op4)
        tdpu_pkg::AluAnd: r = a & s;
        tdpu_pkg::AluEor: r = a ^ s;
        tdpu_pkg::AluLsl: begin
          if (amt == 8'd0) r = a;
          else if (amt < 8'd32) begin
            c = a[5'(6'd32 - {1'b0, amt[4:0]})]; r = a << amt[4:0];
          end else begin
            c = (amt == 8'd32) ? a[0] : 1'b0; r = '0;
          end
        end
        tdpu_pkg::AluLsr: begin
          if (amt == 8'd0) r = a;
          else if (amt < 8'd32) begin
            c = a[amt[4:0] - 5'd1]; r = a >> amt[4:0];
          end else begin
            c = (amt == 8'd32) ? a[31] : 1'b0; r = '0;
          end
        end
        tdpu_pkg::AluAsr: begin
          if (amt == 8'd0) r = a;
          else if (amt < 8'd32) begin
            c = a[amt[4:0] - 5'd1]; r = $signed(a) >>> amt[4:0];
          end else begin
            c = a[31]; r = {32{a[31]}};
          end
        end
        tdpu_pkg::AluAdc: begin
          do_add = 1'b1; b = s; cin = nzcv[1];
        end
        tdpu_pkg::AluSbc: begin
          do_add = 1'b1; b = ~s; cin = nzcv[1];
        end
        tdpu_pkg::AluRor: begin
          if (amt == 8'd0) r = a;
          else if (amt[4:0] == 5'd0) begin
            c = a[31]; r = a;
          end else begin
            c = a[amt[4:0] - 5'd1];
            r = (a >> amt[4:0]) | (a << (6'd32 - {1'b0, amt[4:0]}));
          end
        end
        tdpu_pkg::AluTst: begin
          r = a & s; wr = 1'b0;
        end
        tdpu_pkg::AluNeg: begin
          do_add = 1'b1; a = '0; b = ~s; cin = 1'b1;
        end
        tdpu_pkg::AluCmp: begin
          do_add = 1'b1; b = ~s; cin = 1'b1; wr = 1'b0;
        end
        tdpu_pkg::AluCmn: begin
          do_add = 1'b1; b = s; wr = 1'b0;
        end
        tdpu_pkg::AluOrr: r = a | s;
        tdpu_pkg::AluMul: r = a * s;
        tdpu_pkg::AluBic: r = a & ~s;
        default:          r = ~s;
      endcase
    end
    sum = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    if (do_add) begin
      r = sum[31:0];
      c = sum[32];
      v = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);
    end
    if (setnz) begin
      n = r[31]; z = (r == '0);
    end
    res.handled = hd;
    res.wr = wr;
    res.rd = wr ? rd : 3'd0;
    res.res = wr ? r : '0;
    res.nzcv = {n, z, c, v};
  end

endmodule
`default_nettype wire

// ----- rtl/core/thumb_data_processing_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thumb_data_processing_unit
// Thumb data-processing execute unit: register file in RAM, read / execute /
// write back with forwarding.
//
// channel  dir  data
// in_      in   tdata[15:0] instr
// out_     out  tdata[47:0] handled, dest_written, dest_index, dest_value,
//                           flag_n, flag_z, flag_c, flag_v, zero pad
//
// One request per cycle unless the output stalls, which holds the pipe.
// Reads to two RAM copies feed stage 1, which executes and writes back,
// forwarding its own write into the next read; stage 2 is the output register.
// Reset clears flags and marks all registers as zero via valid bits.
// ----------------------------------------------------------------------------
module thumb_data_processing_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] instr
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // handled, dest_written, dest_index[2:0],
                                       // dest_value[31:0], n, z, c, v, 7'b0
);

  logic        s1_v_r, out_v_r;
  logic [15:0] s1_ins_r;
  logic [2:0]  ia, ib;
  logic [2:0]  s1_ia, s1_ib;
  logic [31:0] ra, rb, fa, fb;
  logic [3:0]  nzcv_r;
  logic [7:0]  vld_r;
  logic [47:0] out_r;
  logic        adv, go;
  logic        wb_r;
  logic [2:0]  wb_rd_r;
  logic [31:0] wb_val_r;
  tdpu_pkg::exec_res_t ex;

  assign adv = !out_v_r || out_tready;
  assign in_tready = adv;
  assign go = s1_v_r && adv;

  function automatic logic [2:0] sel_a(input logic [15:0] w);
    if (w[15:13] == 3'b001) return w[10:8];
    else if (w[15:10] == 6'b010000) return w[2:0];
    else return w[5:3];
  endfunction

  assign ia = sel_a(in_tdata);
  assign ib = (in_tdata[15:10] == 6'b010000 || in_tdata[15:11] != 5'b00011)
              ? in_tdata[5:3] : in_tdata[8:6];
  assign s1_ia = sel_a(s1_ins_r);
  assign s1_ib = (s1_ins_r[15:10] == 6'b010000 || s1_ins_r[15:11] != 5'b00011)
                 ? s1_ins_r[5:3] : s1_ins_r[8:6];

  // wb_* registers the write made at the same clock edge as this read; RAM missed it.
  always_comb begin
    fa = !vld_r[s1_ia] ? '0 : ra;
    fb = !vld_r[s1_ib] ? '0 : rb;
    if (wb_r && wb_rd_r == s1_ia) fa = wb_val_r;
    if (wb_r && wb_rd_r == s1_ib) fb = wb_val_r;
  end

  tdpu_alu u_alu (
    .instr (s1_ins_r),
    .reg_a (fa),
    .reg_b (fb),
    .nzcv  (nzcv_r),
    .res   (ex)
  );

  logic we;
  assign we = go && ex.wr;

  tdpu_ram #(.Width(tdpu_pkg::DataW), .Depth(tdpu_pkg::RegDepth)) u_ram_a (
    .clk(clk), .we(we), .waddr(ex.rd), .wdata(ex.res),
    .raddr(adv ? ia : s1_ia), .rdata(ra));
  tdpu_ram #(.Width(tdpu_pkg::DataW), .Depth(tdpu_pkg::RegDepth)) u_ram_b (
    .clk(clk), .we(we), .waddr(ex.rd), .wdata(ex.res),
    .raddr(adv ? ib : s1_ib), .rdata(rb));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      out_v_r <= 1'b0;
      nzcv_r <= '0;
      vld_r <= '0;
      wb_r <= 1'b0;
    end else begin
      wb_r <= we;
      if (adv) begin
        s1_v_r <= in_tvalid;
        out_v_r <= s1_v_r;
      end
      if (go) begin
        nzcv_r <= ex.nzcv;
        if (ex.wr) vld_r[ex.rd] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    wb_rd_r <= ex.rd;
    wb_val_r <= ex.res;
    if (adv) s1_ins_r <= in_tdata;
    if (go) out_r <= {7'd0, ex.nzcv[0], ex.nzcv[1], ex.nzcv[2], ex.nzcv[3],
                      ex.res, ex.rd, ex.wr, ex.handled};
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = out_r;

endmodule
`default_nettype wire
